// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/qslerp_pkg.sv
`timescale 1ns / 1ps
package qslerp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int AW = 34;
	localparam int SQ_STAGES = 31;
	localparam int DIV_BITS = 20;
	localparam int ONE_Q14 = 16384;
	localparam logic [14:0] THR_RESET = 15'd16383;

	localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127
	};

	typedef struct packed {
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] start_z;
		logic signed [15:0] start_w;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic signed [15:0] end_z;
		logic signed [15:0] end_w;
		logic [14:0] blend;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_w;
	} result_t;

	// what rides alongside the arithmetic from stage 1 through the weight division
	typedef struct packed {
		logic [3:0][15:0] s;
		logic [3:0][15:0] e;
		logic [14:0] t;
		logic flip;
		logic lin;
	} side_t;

endpackage

// File: rtl/core/qslerp_sqrt.sv
`timescale 1ns / 1ps
module qslerp_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  qslerp_pkg::side_t side,
	input  logic [60:0] rad,
	input  logic [30:0] c,
	output logic root_valid,
	output qslerp_pkg::side_t root_side,
	output logic [30:0] root,
	output logic [30:0] root_c
);
	localparam int N = qslerp_pkg::SQ_STAGES;

	logic [61:0] rem_s [N];
	logic [61:0] res_s [N];
	logic [30:0] c_s [N];
	qslerp_pkg::side_t side_s [N];
	logic val_s [N];

	logic [61:0] rem_in [N];
	logic [61:0] res_in [N];
	logic [30:0] c_in [N];
	qslerp_pkg::side_t side_in [N];
	logic val_in [N];
	logic [61:0] rem_nx [N];
	logic [61:0] res_nx [N];

	always_comb begin
		rem_in[0] = {1'b0, rad};
		res_in[0] = '0;
		c_in[0] = c;
		side_in[0] = side;
		val_in[0] = valid;
		for (int k = 1; k < N; k++) begin
			rem_in[k] = rem_s[k-1];
			res_in[k] = res_s[k-1];
			c_in[k] = c_s[k-1];
			side_in[k] = side_s[k-1];
			val_in[k] = val_s[k-1];
		end
	end

	// one result bit per stage, trial bit walks down two places each time
	always_comb begin
		for (int k = 0; k < N; k++) begin
			logic [61:0] bitv;
			logic [61:0] trial;
			bitv = 62'd1 << (60 - 2 * k);
			trial = res_in[k] + bitv;
			if (rem_in[k] >= trial) begin
				rem_nx[k] = rem_in[k] - trial;
				res_nx[k] = (res_in[k] >> 1) + bitv;
			end else begin
				rem_nx[k] = rem_in[k];
				res_nx[k] = res_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) val_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) val_s[k] <= val_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_nx[k];
				res_s[k] <= res_nx[k];
				c_s[k] <= c_in[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign root_valid = val_s[N-1];
	assign root_side = side_s[N-1];
	assign root = res_s[N-1][30:0];
	assign root_c = c_s[N-1];
endmodule

// File: rtl/core/qslerp_vec.sv
`timescale 1ns / 1ps
module qslerp_vec (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  qslerp_pkg::side_t side,
	input  logic [30:0] c,
	input  logic [30:0] sn,
	output logic theta_valid,
	output qslerp_pkg::side_t theta_side,
	output logic signed [qslerp_pkg::AW-1:0] theta
);
	localparam int N = qslerp_pkg::STEPS;
	localparam int AW = qslerp_pkg::AW;

	logic signed [AW-1:0] x_s [N];
	logic signed [AW-1:0] y_s [N];
	logic signed [AW-1:0] z_s [N];
	qslerp_pkg::side_t side_s [N];
	logic val_s [N];

	logic signed [AW-1:0] x_in [N];
	logic signed [AW-1:0] y_in [N];
	logic signed [AW-1:0] z_in [N];
	qslerp_pkg::side_t side_in [N];
	logic val_in [N];
	logic signed [AW-1:0] x_nx [N];
	logic signed [AW-1:0] y_nx [N];
	logic signed [AW-1:0] z_nx [N];

	always_comb begin
		x_in[0] = $signed({{(AW-31){1'b0}}, c});
		y_in[0] = $signed({{(AW-31){1'b0}}, sn});
		z_in[0] = '0;
		side_in[0] = side;
		val_in[0] = valid;
		for (int k = 1; k < N; k++) begin
			x_in[k] = x_s[k-1];
			y_in[k] = y_s[k-1];
			z_in[k] = z_s[k-1];
			side_in[k] = side_s[k-1];
			val_in[k] = val_s[k-1];
		end
	end

	// vectoring: drive y to zero, angle gathers in z
	always_comb begin
		for (int k = 0; k < N; k++) begin
			logic signed [AW-1:0] dx;
			logic signed [AW-1:0] dy;
			logic signed [AW-1:0] at;
			dx = y_in[k] >>> k;
			dy = x_in[k] >>> k;
			at = $signed({{(AW-30){1'b0}}, qslerp_pkg::ATAN_Q30[k]});
			if (y_in[k] > 0) begin
				x_nx[k] = x_in[k] + dx;
				y_nx[k] = y_in[k] - dy;
				z_nx[k] = z_in[k] + at;
			end else begin
				x_nx[k] = x_in[k] - dx;
				y_nx[k] = y_in[k] + dy;
				z_nx[k] = z_in[k] - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) val_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) val_s[k] <= val_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				x_s[k] <= x_nx[k];
				y_s[k] <= y_nx[k];
				z_s[k] <= z_nx[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign theta_valid = val_s[N-1];
	assign theta_side = side_s[N-1];
	assign theta = z_s[N-1];
endmodule

// File: rtl/core/qslerp_rot.sv
`timescale 1ns / 1ps
module qslerp_rot (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  qslerp_pkg::side_t side,
	input  logic signed [qslerp_pkg::AW-1:0] ang [3],
	output logic sine_valid,
	output qslerp_pkg::side_t sine_side,
	output logic signed [qslerp_pkg::AW-1:0] sine [3]
);
	localparam int N = qslerp_pkg::STEPS;
	localparam int AW = qslerp_pkg::AW;
	localparam int LN = 3;

	logic signed [AW-1:0] x_s [N][LN];
	logic signed [AW-1:0] y_s [N][LN];
	logic signed [AW-1:0] z_s [N][LN];
	qslerp_pkg::side_t side_s [N];
	logic val_s [N];

	logic signed [AW-1:0] x_in [N][LN];
	logic signed [AW-1:0] y_in [N][LN];
	logic signed [AW-1:0] z_in [N][LN];
	qslerp_pkg::side_t side_in [N];
	logic val_in [N];
	logic signed [AW-1:0] x_nx [N][LN];
	logic signed [AW-1:0] y_nx [N][LN];
	logic signed [AW-1:0] z_nx [N][LN];

	always_comb begin
		for (int j = 0; j < LN; j++) begin
			x_in[0][j] = $signed({{(AW-31){1'b0}}, 31'h4000_0000});
			y_in[0][j] = '0;
			z_in[0][j] = ang[j];
		end
		side_in[0] = side;
		val_in[0] = valid;
		for (int k = 1; k < N; k++) begin
			for (int j = 0; j < LN; j++) begin
				x_in[k][j] = x_s[k-1][j];
				y_in[k][j] = y_s[k-1][j];
				z_in[k][j] = z_s[k-1][j];
			end
			side_in[k] = side_s[k-1];
			val_in[k] = val_s[k-1];
		end
	end

	// rotation from unit x, three angles side by side, gain cancels later
	always_comb begin
		for (int k = 0; k < N; k++) begin
			for (int j = 0; j < LN; j++) begin
				logic signed [AW-1:0] dx;
				logic signed [AW-1:0] dy;
				logic signed [AW-1:0] at;
				dx = y_in[k][j] >>> k;
				dy = x_in[k][j] >>> k;
				at = $signed({{(AW-30){1'b0}}, qslerp_pkg::ATAN_Q30[k]});
				if (z_in[k][j] >= 0) begin
					x_nx[k][j] = x_in[k][j] - dx;
					y_nx[k][j] = y_in[k][j] + dy;
					z_nx[k][j] = z_in[k][j] - at;
				end else begin
					x_nx[k][j] = x_in[k][j] + dx;
					y_nx[k][j] = y_in[k][j] - dy;
					z_nx[k][j] = z_in[k][j] + at;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) val_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) val_s[k] <= val_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				for (int j = 0; j < LN; j++) begin
					x_s[k][j] <= x_nx[k][j];
					y_s[k][j] <= y_nx[k][j];
					z_s[k][j] <= z_nx[k][j];
				end
				side_s[k] <= side_in[k];
			end
		end
	end

	assign sine_valid = val_s[N-1];
	assign sine_side = side_s[N-1];
	always_comb begin
		for (int j = 0; j < LN; j++) sine[j] = y_s[N-1][j];
	end
endmodule

// File: rtl/core/qslerp_div.sv
`timescale 1ns / 1ps
module qslerp_div (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  qslerp_pkg::side_t side,
	input  logic signed [qslerp_pkg::AW-1:0] num [2],
	input  logic signed [qslerp_pkg::AW-1:0] den,
	output logic wt_valid,
	output qslerp_pkg::side_t wt_side,
	output logic [20:0] wt [2]
);
	localparam int N = qslerp_pkg::DIV_BITS;
	localparam int AW = qslerp_pkg::AW;
	localparam int LN = 2;

	logic [AW-1:0] rem_s [N][LN];
	logic [N-1:0] quo_s [N][LN];
	logic zero_s [N][LN];
	logic big_s [N][LN];
	logic [AW-1:0] den_s [N];
	qslerp_pkg::side_t side_s [N];
	logic val_s [N];

	logic [AW-1:0] rem_in [N][LN];
	logic [N-1:0] quo_in [N][LN];
	logic zero_in [N][LN];
	logic big_in [N][LN];
	logic [AW-1:0] den_in [N];
	qslerp_pkg::side_t side_in [N];
	logic val_in [N];
	logic [AW-1:0] rem_nx [N][LN];
	logic [N-1:0] quo_nx [N][LN];

	// a non-positive numerator gives zero, num >= den saturates at one
	always_comb begin
		for (int j = 0; j < LN; j++) begin
			rem_in[0][j] = num[j];
			quo_in[0][j] = '0;
			zero_in[0][j] = (num[j] <= 0);
			big_in[0][j] = (num[j] >= den);
		end
		den_in[0] = den;
		side_in[0] = side;
		val_in[0] = valid;
		for (int k = 1; k < N; k++) begin
			for (int j = 0; j < LN; j++) begin
				rem_in[k][j] = rem_s[k-1][j];
				quo_in[k][j] = quo_s[k-1][j];
				zero_in[k][j] = zero_s[k-1][j];
				big_in[k][j] = big_s[k-1][j];
			end
			den_in[k] = den_s[k-1];
			side_in[k] = side_s[k-1];
			val_in[k] = val_s[k-1];
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < N; k++) begin
			for (int j = 0; j < LN; j++) begin
				logic [AW-1:0] r2;
				logic ge;
				r2 = {rem_in[k][j][AW-2:0], 1'b0};
				ge = (r2 >= den_in[k]);
				rem_nx[k][j] = ge ? (r2 - den_in[k]) : r2;
				quo_nx[k][j] = {quo_in[k][j][N-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) val_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) val_s[k] <= val_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				for (int j = 0; j < LN; j++) begin
					rem_s[k][j] <= rem_nx[k][j];
					quo_s[k][j] <= quo_nx[k][j];
					zero_s[k][j] <= zero_in[k][j];
					big_s[k][j] <= big_in[k][j];
				end
				den_s[k] <= den_in[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign wt_valid = val_s[N-1];
	assign wt_side = side_s[N-1];
	always_comb begin
		for (int j = 0; j < LN; j++) begin
			if (zero_s[N-1][j]) wt[j] = '0;
			else if (big_s[N-1][j]) wt[j] = 21'h10_0000;
			else wt[j] = {1'b0, quo_s[N-1][j]};
		end
	end
endmodule

// File: rtl/core/quaternion_slerp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Spherical interpolation of two Q2.14 quaternions by a Q1.14 blend factor, taking the
// shorter arc and falling back to linear weights when |dot| exceeds near_parallel_threshold
// (cfg_we/cfg_wdata, reset 16383) or the sine of theta is not positive. Fully pipelined:
// one item is accepted every cycle while item_stall is low; results leave in input order.
// Parts in order: component products, dot product, radicand, square root (one result bit
// per stage), arc cosine CORDIC, angle scaling, sine CORDIC, weight division (one quotient
// bit per stage), weighting, rounding and an output register; the CORDICs run 16 steps by
// default. A two-entry output register with skid keeps the intake open while a finished
// result waits; item_stall rises only when both are full, and the whole pipeline holds.
module quaternion_slerp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic item_valid,
	output logic item_stall,
	input  qslerp_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output qslerp_pkg::result_t result
);
	localparam int AW = qslerp_pkg::AW;

	logic [14:0] thr_q;
	logic en;
	logic skid_v_q;
	logic ov_q;
	qslerp_pkg::result_t skid_q;
	qslerp_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= qslerp_pkg::THR_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	assign en = !skid_v_q;
	assign item_stall = skid_v_q;

	// stage 1: component products
	qslerp_pkg::side_t side_in;
	logic v_s1;
	qslerp_pkg::side_t side_s1;
	logic signed [31:0] prod_s1 [4];

	always_comb begin
		side_in.s[0] = item.start_x;
		side_in.s[1] = item.start_y;
		side_in.s[2] = item.start_z;
		side_in.s[3] = item.start_w;
		side_in.e[0] = item.end_x;
		side_in.e[1] = item.end_y;
		side_in.e[2] = item.end_z;
		side_in.e[3] = item.end_w;
		side_in.t = (item.blend > 15'(qslerp_pkg::ONE_Q14)) ? 15'(qslerp_pkg::ONE_Q14)
			: item.blend;
		side_in.flip = 1'b0;
		side_in.lin = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				prod_s1[k] <= $signed(side_in.s[k]) * $signed(side_in.e[k]);
			side_s1 <= side_in;
		end
	end

	// stage 2: dot product, arc choice, linear test, clamp to one
	logic signed [33:0] dot;
	logic signed [33:0] dot_neg;
	logic [32:0] dabs;
	qslerp_pkg::side_t side_nx2;
	logic v_s2;
	qslerp_pkg::side_t side_s2;
	logic [30:0] c_s2;

	always_comb begin
		dot = '0;
		for (int k = 0; k < 4; k++)
			dot = dot + $signed({{2{prod_s1[k][31]}}, prod_s1[k]});
		dot_neg = -dot;
		dabs = dot[33] ? dot_neg[32:0] : dot[32:0];
		side_nx2 = side_s1;
		side_nx2.flip = dot[33];
		side_nx2.lin = (dabs > {4'b0, thr_q, 14'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_nx2;
			c_s2 <= (dabs >= 33'h1000_0000) ? 31'h4000_0000 : {1'b0, dabs[27:0], 2'b00};
		end
	end

	// stage 3: radicand for the sine of theta
	logic [61:0] csq;
	logic v_s3;
	qslerp_pkg::side_t side_s3;
	logic [30:0] c_s3;
	logic [60:0] rad_s3;

	assign csq = c_s2 * c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			c_s3 <= c_s2;
			rad_s3 <= 61'h1000_0000_0000_0000 - csq[60:0];
		end
	end

	logic sq_v;
	qslerp_pkg::side_t sq_side;
	logic [30:0] sq_root;
	logic [30:0] sq_c;

	qslerp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(v_s3), .side(side_s3), .rad(rad_s3), .c(c_s3),
		.root_valid(sq_v), .root_side(sq_side), .root(sq_root), .root_c(sq_c)
	);

	logic vec_v;
	qslerp_pkg::side_t vec_side;
	logic signed [AW-1:0] vec_theta;

	qslerp_vec u_vec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(sq_v), .side(sq_side), .c(sq_c), .sn(sq_root),
		.theta_valid(vec_v), .theta_side(vec_side), .theta(vec_theta)
	);

	// stage 4: pass theta on and scale it by 1-t and by t
	logic [14:0] u0;
	logic signed [49:0] pa0;
	logic signed [49:0] pa1;
	logic v_s4;
	qslerp_pkg::side_t side_s4;
	logic signed [AW-1:0] ang_s4 [3];

	assign u0 = 15'(qslerp_pkg::ONE_Q14) - vec_side.t;
	assign pa0 = vec_theta * $signed({1'b0, u0});
	assign pa1 = vec_theta * $signed({1'b0, vec_side.t});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= vec_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= vec_side;
			ang_s4[0] <= vec_theta;
			ang_s4[1] <= pa0[AW+13:14];
			ang_s4[2] <= pa1[AW+13:14];
		end
	end

	logic rot_v;
	qslerp_pkg::side_t rot_side;
	logic signed [AW-1:0] rot_y [3];

	qslerp_rot u_rot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(v_s4), .side(side_s4), .ang(ang_s4),
		.sine_valid(rot_v), .sine_side(rot_side), .sine(rot_y)
	);

	// a non-positive sine of theta falls back to linear weights
	qslerp_pkg::side_t div_side_in;
	logic signed [AW-1:0] div_num [2];

	always_comb begin
		div_side_in = rot_side;
		div_side_in.lin = rot_side.lin || (rot_y[0] <= 0);
		div_num[0] = rot_y[1];
		div_num[1] = rot_y[2];
	end

	logic div_v;
	qslerp_pkg::side_t div_side;
	logic [20:0] div_w [2];

	qslerp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(rot_v), .side(div_side_in), .num(div_num), .den(rot_y[0]),
		.wt_valid(div_v), .wt_side(div_side), .wt(div_w)
	);

	// stage 5: weight selection and products
	logic [14:0] u0w;
	logic [20:0] w0;
	logic [20:0] w1;
	logic signed [21:0] w0s;
	logic signed [21:0] w1s;
	logic v_s5;
	logic signed [37:0] p0_s5 [4];
	logic signed [37:0] p1_s5 [4];

	always_comb begin
		u0w = 15'(qslerp_pkg::ONE_Q14) - div_side.t;
		if (div_side.lin) begin
			w0 = {u0w, 6'b0};
			w1 = {div_side.t, 6'b0};
		end else begin
			w0 = div_w[0];
			w1 = div_w[1];
		end
		w0s = $signed({1'b0, w0});
		w1s = div_side.flip ? -$signed({1'b0, w1}) : $signed({1'b0, w1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= div_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				p0_s5[k] <= w0s * $signed(div_side.s[k]);
				p1_s5[k] <= w1s * $signed(div_side.e[k]);
			end
		end
	end

	// stage 6: sum, round half up, saturate
	logic [3:0][15:0] sat;
	logic fin_v_s6;
	qslerp_pkg::result_t fin_s6;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [38:0] acc;
			logic signed [18:0] sh;
			acc = $signed({p0_s5[k][37], p0_s5[k]}) + $signed({p1_s5[k][37], p1_s5[k]})
				+ 39'sd524288;
			sh = acc[38:20];
			if (sh > 19'sd32767) sat[k] = 16'h7fff;
			else if (sh < -19'sd32768) sat[k] = 16'h8000;
			else sat[k] = sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s6 <= 1'b0;
		else if (en) fin_v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s6.out_x <= sat[0];
			fin_s6.out_y <= sat[1];
			fin_s6.out_z <= sat[2];
			fin_s6.out_w <= sat[3];
		end
	end

	// output register with skid
	logic out_free;
	assign out_free = !ov_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) skid_v_q <= 1'b0;
		end else if (fin_v_s6) begin
			ov_q <= 1'b1;
			if (!out_free) skid_v_q <= 1'b1;
		end else if (out_free) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) res_q <= skid_q;
		end else if (fin_v_s6) begin
			if (out_free) res_q <= fin_s6;
			else skid_q <= fin_s6;
		end
	end

	assign result_valid = ov_q;
	assign result = res_q;

	`QS_ASSERT_SAME(a_skid_has_out, skid_v_q, ov_q, "skid holds an item with output empty")
	`QS_ASSERT_NEXT(a_skid_catch, ov_q && result_stall && !skid_v_q && fin_v_s6, skid_v_q,
		"stalled output did not catch finished item in skid")
	`QS_ASSERT_NEXT(a_skid_drain, skid_v_q && !result_stall, !skid_v_q && ov_q,
		"skid item not moved to output")
endmodule
